/* rtl/cfdl_pkg.sv */
// cfdl_pkg: shared types and constants for the cubic fractional delay line bank
// used by cfdl_store, cfdl_interp and cubic_fractional_delay_lines_core
`timescale 1ns / 1ps

package cfdl_pkg;

  localparam int LINES_DEF       = 8;
  localparam int DEPTH_DEF       = 262144;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int ACTION_W = 2;
  localparam int LINE_W   = 3;
  localparam int WHOLE_W  = 18;
  localparam int RING_W   = 19;

  localparam logic [RING_W-1:0] RING_RESET = 19'd192000;
  localparam logic [RING_W-1:0] RING_MIN   = 19'd4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ      = 2'd0,
    ACT_WRITE_ONE = 2'd1,
    ACT_WRITE_ALL = 2'd2,
    ACT_ADVANCE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_BASE,
    ST_FETCH,
    ST_DRAIN,
    ST_INTERP,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic              en;
    logic              all_lines;
    logic [LINE_W-1:0] line;
  } wr_cmd_t;

  typedef struct packed {
    logic              en;
    logic [LINE_W-1:0] line;
    logic              ch;
  } rd_cmd_t;

endpackage

/* rtl/cfdl_store.sv */
// cfdl_store: one synchronous ring memory per line and channel, shared address
// clears every entry after reset, one address per cycle; depends on cfdl_pkg
`timescale 1ns / 1ps

module cfdl_store #(
  parameter int LINES       = cfdl_pkg::LINES_DEF,
  parameter int DEPTH       = cfdl_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = cfdl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cfdl_pkg::wr_cmd_t            wr,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [SAMPLE_BITS-1:0]       wdata_left,
  input  logic [SAMPLE_BITS-1:0]       wdata_right,
  input  cfdl_pkg::rd_cmd_t            rd,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [SAMPLE_BITS-1:0]       rdata,
  output logic                         clearing
);
  import cfdl_pkg::*;

  localparam int LANES  = 2 * LINES;
  localparam int LANE_W = $clog2(LANES);
  localparam int ADDR_W = $clog2(DEPTH);

  logic [ADDR_W-1:0]      clr_addr;
  logic [ADDR_W-1:0]      wa;
  logic [LANE_W-1:0]      rd_lane;
  logic [SAMPLE_BITS-1:0] lane_data [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign wa = clearing ? clr_addr : waddr;

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_lane <= LANE_W'(int'(rd.line) * 2 + int'(rd.ch));
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic                   we;
    logic [SAMPLE_BITS-1:0] wd;

    assign we = clearing | (wr.en & (wr.all_lines | (int'(wr.line) == g / 2)));
    assign wd = clearing ? '0 : (((g % 2) == 0) ? wdata_left : wdata_right);

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wa] <= wd;
      end
      if (rd.en) begin
        lane_data[g] <= mem[raddr];
      end
    end
  end

  assign rdata = lane_data[rd_lane];

endmodule

/* rtl/cfdl_interp.sv */
// cfdl_interp: cubic interpolation of four taps by Horner steps on one multiplier
// each step is a registered multiply then a rounded add; depends on cfdl_pkg
`timescale 1ns / 1ps

module cfdl_interp #(
  parameter int SAMPLE_BITS = cfdl_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = cfdl_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] taps [4],
  input  logic [FRAC_BITS-1:0]          frac,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] value
);
  import cfdl_pkg::*;

  localparam int AW = SAMPLE_BITS + 5;
  localparam int PW = AW + FRAC_BITS + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic [1:0] LAST_STEP = 2'd2;

  logic                 run;
  logic                 phase;
  logic [1:0]           step;
  logic signed [AW-1:0] a0, a1, a2, a3, acc;
  logic signed [AW-1:0] y0, y1, y2, y3;
  logic signed [AW-1:0] c0, c1;
  logic signed [PW-1:0] prod;
  logic [FRAC_BITS-1:0] f_q;
  logic signed [FRAC_BITS:0] f_s;
  logic signed [AW-1:0] mul_in;
  logic signed [AW-1:0] addend;
  logic signed [PW-1:0] rnd;
  logic signed [AW:0]   sh;
  logic signed [AW:0]   sum;
  logic signed [AW-1:0] acc_next;
  logic [SAMPLE_BITS-1:0] sat;
  logic [AW-SAMPLE_BITS:0] upper;

  assign y0 = AW'(taps[0]);
  assign y1 = AW'(taps[1]);
  assign y2 = AW'(taps[2]);
  assign y3 = AW'(taps[3]);
  assign c0 = y3 - y2 - y0 + y1;
  assign c1 = y0 - y1 - c0;

  assign f_s    = $signed({1'b0, f_q});
  assign mul_in = (step == 2'd0) ? a0 : acc;

  always_comb begin
    unique case (step)
      2'd0:    addend = a1;
      2'd1:    addend = a2;
      default: addend = a3;
    endcase
  end

  // round half up, then floor shift
  assign rnd      = prod + HALF;
  assign sh       = $signed(rnd[PW-1:FRAC_BITS]);
  assign sum      = sh + (AW+1)'(addend);
  assign acc_next = $signed(sum[AW-1:0]);

  assign upper = acc_next[AW-1:SAMPLE_BITS-1];
  always_comb begin
    if ((&upper) || !(|upper)) begin
      sat = acc_next[SAMPLE_BITS-1:0];
    end else if (acc_next[AW-1]) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      phase <= 1'b0;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        phase <= 1'b0;
        step  <= '0;
      end else if (run) begin
        phase <= ~phase;
        if (phase) begin
          if (step == LAST_STEP) begin
            run  <= 1'b0;
            done <= 1'b1;
          end else begin
            step <= step + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a0  <= c0;
      a1  <= c1;
      a2  <= y2 - y0;
      a3  <= y1;
      f_q <= frac;
    end
    if (run && !phase) begin
      prod <= mul_in * f_s;
    end
    if (run && phase) begin
      acc <= acc_next;
      if (step == LAST_STEP) begin
        value <= $signed(sat);
      end
    end
  end

endmodule

/* rtl/cubic_fractional_delay_lines_core.sv */
// cubic_fractional_delay_lines_core: bank of stereo delay lines with cubic reads
// uses cfdl_pkg, cfdl_store (ring memories) and cfdl_interp (Horner unit)
// writes and pointer advances do not raise busy; busy stays low through them
// a read holds busy high, so the next read waits until it ends: clamp, base address,
// four taps through the one memory read port, then three multiply and add steps;
// done pulses in the first cycle busy is low again
// a read of a line outside the bank gives zero on done the next cycle
// after reset busy stays high while every ring entry is zeroed;
// the receiver cannot stall, each word on value is valid only while done is high
`timescale 1ns / 1ps

module cubic_fractional_delay_lines_core #(
  parameter int LINES       = cfdl_pkg::LINES_DEF,
  parameter int DEPTH       = cfdl_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = cfdl_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = cfdl_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [cfdl_pkg::ACTION_W-1:0]    action,
  input  logic [cfdl_pkg::LINE_W-1:0]      line,
  input  logic                             channel,
  input  logic signed [SAMPLE_BITS-1:0]    sample_left,
  input  logic signed [SAMPLE_BITS-1:0]    sample_right,
  input  logic [cfdl_pkg::WHOLE_W-1:0]     delay_whole,
  input  logic [FRAC_BITS-1:0]             delay_frac,
  output logic                             done,
  output logic signed [SAMPLE_BITS-1:0]    value,
  input  logic                             cfg_we,
  input  logic [cfdl_pkg::RING_W-1:0]      cfg_wdata
);
  import cfdl_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LEN_W = PTR_W + 1;
  localparam int CMP_W = (WHOLE_W > LEN_W) ? WHOLE_W : LEN_W;
  localparam logic [1:0] LAST_TAP = 2'd3;

  function automatic logic [LEN_W-1:0] eff_len(input logic [RING_W-1:0] r);
    logic [LEN_W-1:0] l;
    if (r < RING_MIN) begin
      l = LEN_W'(RING_MIN);
    end else if (32'(r) > 32'(DEPTH)) begin
      l = LEN_W'(DEPTH);
    end else begin
      l = LEN_W'(r);
    end
    return l;
  endfunction

  state_t state, state_next;

  logic                   accept;
  logic                   line_ok;
  action_t                act;
  logic [LEN_W-1:0]       len_q;
  logic [LEN_W-1:0]       cfg_len;
  logic [PTR_W-1:0]       wp;
  logic [LEN_W-1:0]       wp_inc;
  logic [LINE_W-1:0]      line_q;
  logic                   ch_q;
  logic [WHOLE_W-1:0]     whole_q;
  logic [FRAC_BITS-1:0]   frac_q;
  logic [PTR_W-1:0]       d_q;
  logic [FRAC_BITS-1:0]   f_eff;
  logic [PTR_W-1:0]       addr;
  logic [LEN_W-1:0]       addr_inc;
  logic [LEN_W:0]         base_raw;
  logic [LEN_W:0]         base_wrap;
  logic [1:0]             tap_cnt;
  logic [1:0]             cap_idx;
  logic                   rvld;
  logic signed [SAMPLE_BITS-1:0] taps [4];
  logic [SAMPLE_BITS-1:0] rdata;
  logic                   clearing;
  wr_cmd_t                wr_cmd;
  rd_cmd_t                rd_cmd;
  logic                   h_start;
  logic                   h_done;
  logic signed [SAMPLE_BITS-1:0] h_value;

  assign act     = action_t'(action);
  assign accept  = start && !busy;
  assign line_ok = int'(line) < LINES;
  assign cfg_len = eff_len(cfg_wdata);

  always_comb begin
    wr_cmd.en        = accept && ((act == ACT_WRITE_ONE && line_ok) || act == ACT_WRITE_ALL);
    wr_cmd.all_lines = (act == ACT_WRITE_ALL);
    wr_cmd.line      = line;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && act == ACT_READ && line_ok) state_next = ST_CLAMP;
      ST_CLAMP:  state_next = ST_BASE;
      ST_BASE:   state_next = ST_FETCH;
      ST_FETCH:  if (tap_cnt == LAST_TAP) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_INTERP;
      ST_INTERP: state_next = ST_WAIT;
      ST_WAIT:   if (h_done) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy        = clearing || (state != ST_IDLE);
    rd_cmd.en   = (state == ST_FETCH);
    rd_cmd.line = line_q;
    rd_cmd.ch   = ch_q;
    h_start     = (state == ST_INTERP);
  end

  assign wp_inc    = LEN_W'(wp) + 1'b1;
  assign addr_inc  = LEN_W'(addr) + 1'b1;
  // oldest tap sits at wp - d - 1, taken modulo the ring length
  assign base_raw  = (LEN_W+1)'(wp) + (LEN_W+1)'(len_q) - (LEN_W+1)'(d_q) - 1'b1;
  assign base_wrap = (base_raw >= (LEN_W+1)'(len_q)) ? base_raw - (LEN_W+1)'(len_q) : base_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      len_q   <= eff_len(RING_RESET);
      wp      <= '0;
      tap_cnt <= '0;
      rvld    <= 1'b0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      rvld  <= rd_cmd.en;
      done  <= h_done || (accept && act == ACT_READ && !line_ok);
      if (cfg_we) begin
        len_q <= cfg_len;
        if (LEN_W'(wp) >= cfg_len) begin
          wp <= '0;
        end
      end else if (accept && (act == ACT_WRITE_ALL || act == ACT_ADVANCE)) begin
        wp <= (wp_inc >= len_q) ? '0 : wp_inc[PTR_W-1:0];
      end
      if (state == ST_FETCH) begin
        tap_cnt <= tap_cnt + 1'b1;
      end else begin
        tap_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_q  <= line;
      ch_q    <= channel;
      whole_q <= delay_whole;
      frac_q  <= delay_frac;
    end
    if (state == ST_CLAMP) begin
      if (whole_q == '0) begin
        d_q   <= PTR_W'(1);
        f_eff <= '0;
      end else if (CMP_W'(whole_q) >= CMP_W'(len_q - 1'b1)) begin
        d_q   <= PTR_W'(len_q - 1'b1);
        f_eff <= '0;
      end else begin
        d_q   <= PTR_W'(whole_q);
        f_eff <= frac_q;
      end
    end
    if (state == ST_BASE) begin
      addr <= base_wrap[PTR_W-1:0];
    end else if (state == ST_FETCH) begin
      addr <= (addr_inc == len_q) ? '0 : addr_inc[PTR_W-1:0];
    end
    cap_idx <= tap_cnt;
    if (rvld) begin
      taps[cap_idx] <= $signed(rdata);
    end
    if (h_done) begin
      value <= h_value;
    end else if (accept && act == ACT_READ && !line_ok) begin
      value <= '0;
    end
  end

  cfdl_store #(
    .LINES      (LINES),
    .DEPTH      (DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr_cmd),
    .waddr      (wp),
    .wdata_left (sample_left),
    .wdata_right(sample_right),
    .rd         (rd_cmd),
    .raddr      (addr),
    .rdata      (rdata),
    .clearing   (clearing)
  );

  cfdl_interp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_interp (
    .clk  (clk),
    .rst  (rst),
    .start(h_start),
    .taps (taps),
    .frac (f_eff),
    .done (h_done),
    .value(h_value)
  );

  a_wp_in_ring: assert property (@(posedge clk) disable iff (rst)
    {1'b0, wp} < len_q)
    else $error("write pointer outside ring");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> busy)
    else $error("item accepted during clearing pass");

  a_interp_when_waiting: assert property (@(posedge clk) disable iff (rst)
    h_done |-> state == ST_WAIT)
    else $error("interpolator finished outside wait state");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rd_cmd.en && wr_cmd.en))
    else $error("store read and write in the same cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("word delivered while still busy");

endmodule
